/* rtl/core/mbap_rc_pkg.sv */
// ----------------------------------------------------------------------------
// mbap_rc_pkg
// Shared types and constants for the MBAP response checker: byte kinds,
// frame status codes and the queue word passed from front to back.
// ----------------------------------------------------------------------------
package mbap_rc_pkg;

	localparam int CountW   = 17;
	localparam int HdrBytes = 7;
	localparam int LenExtra = 6;
	localparam int QDepth   = 2;

	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
	localparam logic [7:0]        ExcBit   = 8'h80;

	// position of a byte inside the frame, decided by the front
	typedef enum logic [3:0] {
		KIND_TID_HI,
		KIND_TID_LO,
		KIND_PROTO_HI,
		KIND_PROTO_LO,
		KIND_LEN_HI,
		KIND_LEN_LO,
		KIND_UNIT,
		KIND_FUNC,
		KIND_EXC_CODE,
		KIND_PDU
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EXC      = 3'd1,
		ST_SHORT    = 3'd2,
		ST_TID      = 3'd3,
		ST_PROTO    = 3'd4,
		ST_UNIT     = 3'd5,
		ST_LEN      = 3'd6
	} status_t;

	// register indexes on the APB port
	typedef enum logic {
		REG_EXP_TRANSACTION = 1'b0,
		REG_EXP_UNIT        = 1'b1
	} reg_idx_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        data;
		logic              last;
		logic [CountW-1:0] total;    // saturated byte count including this byte
	} qword_t;

	typedef struct packed {
		logic [15:0] exp_transaction;
		logic [7:0]  exp_unit;
	} cfg_t;

endpackage

/* rtl/core/mbap_rc_front.sv */
// ----------------------------------------------------------------------------
// mbap_rc_front
// Counts frame bytes and tags each accepted byte with its frame position.
// ----------------------------------------------------------------------------
module mbap_rc_front
	import mbap_rc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   accept,
	input  logic   [7:0] in_byte,
	input  logic   last_byte,
	output qword_t push_word
);

	logic [CountW-1:0] count_q;
	logic [CountW-1:0] total;
	kind_t             kind;

	always_comb begin
		total = (count_q == CountMax) ? CountMax : count_q + 1'b1;
		if (count_q >= CountW'(HdrBytes + 2)) begin
			kind = KIND_PDU;
		end else begin
			unique case (count_q[3:0])
				4'd0:    kind = KIND_TID_HI;
				4'd1:    kind = KIND_TID_LO;
				4'd2:    kind = KIND_PROTO_HI;
				4'd3:    kind = KIND_PROTO_LO;
				4'd4:    kind = KIND_LEN_HI;
				4'd5:    kind = KIND_LEN_LO;
				4'd6:    kind = KIND_UNIT;
				4'd7:    kind = KIND_FUNC;
				4'd8:    kind = KIND_EXC_CODE;
				default: kind = KIND_PDU;
			endcase
		end
		push_word.kind  = kind;
		push_word.data  = in_byte;
		push_word.last  = last_byte;
		push_word.total = total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= last_byte ? '0 : total;
		end
	end

endmodule

/* rtl/core/mbap_rc_fifo.sv */
// ----------------------------------------------------------------------------
// mbap_rc_fifo
// Short queue of tagged words between front and back.
// ----------------------------------------------------------------------------
module mbap_rc_fifo
	import mbap_rc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qword_t push_word,
	input  logic   pop,
	output logic   full,
	output logic   not_empty,
	output qword_t pop_word
);

	localparam int PtrW = $clog2(QDepth);
	localparam int CntW = $clog2(QDepth + 1);

	qword_t          mem_q [QDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full      = (cnt_q == CntW'(QDepth));
	assign not_empty = (cnt_q != '0);
	assign pop_word  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(full |-> !push || pop) and (cnt_q <= CntW'(QDepth)))
		else $error("queue overflow");

endmodule

/* rtl/core/mbap_rc_back.sv */
// ----------------------------------------------------------------------------
// mbap_rc_back
// Captures the MBAP header, tracks the exception marker, runs the end of
// frame checks and holds the result word in an output register.
// ----------------------------------------------------------------------------
module mbap_rc_back
	import mbap_rc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_not_empty,
	input  qword_t     q_word,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       byte_valid,
	output logic [7:0] out_byte,
	output logic       frame_done,
	output logic [2:0] frame_status
);

	logic [15:0] tid_q, proto_q, len_q;
	logic [7:0]  unit_q, exc_code_q;
	logic        exc_q;

	logic [15:0] tid_n, proto_n, len_n;
	logic [7:0]  unit_n, exc_code_n;
	logic        exc_n;

	logic        valid_n;
	logic [7:0]  byte_n;
	status_t     status_n;

	logic        out_valid_q, byte_valid_q, frame_done_q;
	logic [7:0]  out_byte_q;
	status_t     status_q;

	assign pop = q_not_empty && (!out_valid_q || !out_stall);

	always_comb begin
		tid_n      = tid_q;
		proto_n    = proto_q;
		len_n      = len_q;
		unit_n     = unit_q;
		exc_n      = exc_q;
		exc_code_n = exc_code_q;
		valid_n    = 1'b0;
		byte_n     = '0;
		status_n   = ST_OK;

		unique case (q_word.kind)
			KIND_TID_HI:   tid_n[15:8]   = q_word.data;
			KIND_TID_LO:   tid_n[7:0]    = q_word.data;
			KIND_PROTO_HI: proto_n[15:8] = q_word.data;
			KIND_PROTO_LO: proto_n[7:0]  = q_word.data;
			KIND_LEN_HI:   len_n[15:8]   = q_word.data;
			KIND_LEN_LO:   len_n[7:0]    = q_word.data;
			KIND_UNIT:     unit_n        = q_word.data;
			KIND_FUNC:     exc_n         = exc_q | (|(q_word.data & ExcBit));
			KIND_EXC_CODE: exc_code_n    = exc_q ? q_word.data : exc_code_q;
			default: ;
		endcase

		// body bytes pass through unless the frame turned into an exception
		if ((q_word.kind == KIND_FUNC || q_word.kind == KIND_EXC_CODE ||
		     q_word.kind == KIND_PDU) && !exc_n) begin
			valid_n = 1'b1;
			byte_n  = q_word.data;
		end

		if (q_word.last) begin
			priority if (q_word.total < CountW'(HdrBytes))                 status_n = ST_SHORT;
			else if (tid_n != cfg.exp_transaction)                           status_n = ST_TID;
			else if (proto_n != '0)                                          status_n = ST_PROTO;
			else if (unit_n != cfg.exp_unit)                                 status_n = ST_UNIT;
			else if (q_word.total != {1'b0, len_n} + CountW'(LenExtra))      status_n = ST_LEN;
			else if (exc_n)                                                  status_n = ST_EXC;
			else                                                             status_n = ST_OK;
			if (exc_n) begin
				valid_n = 1'b1;
				byte_n  = exc_code_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tid_q      <= '0;
			proto_q    <= '0;
			len_q      <= '0;
			unit_q     <= '0;
			exc_q      <= 1'b0;
			exc_code_q <= '0;
		end else if (pop) begin
			if (q_word.last) begin
				tid_q      <= '0;
				proto_q    <= '0;
				len_q      <= '0;
				unit_q     <= '0;
				exc_q      <= 1'b0;
				exc_code_q <= '0;
			end else begin
				tid_q      <= tid_n;
				proto_q    <= proto_n;
				len_q      <= len_n;
				unit_q     <= unit_n;
				exc_q      <= exc_n;
				exc_code_q <= exc_code_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_valid_q <= valid_n;
			out_byte_q   <= byte_n;
			frame_done_q <= q_word.last;
			status_q     <= status_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_valid   = byte_valid_q;
	assign out_byte     = out_byte_q;
	assign frame_done   = frame_done_q;
	assign frame_status = status_q;

	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !frame_done_q |-> status_q == ST_OK)
		else $error("status set on a word that does not end the frame");

	a_idle_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !byte_valid_q |-> out_byte_q == '0)
		else $error("byte not zero while byte_valid is low");

	a_exc_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_done_q && status_q == ST_EXC |-> byte_valid_q)
		else $error("exception status without exception code");

endmodule

/* rtl/core/mbap_response_checker.sv */
// ----------------------------------------------------------------------------
// mbap_response_checker
// Modbus TCP response deframer: captures the MBAP header, forwards PDU bytes
// and reports a frame status on the word for the final byte.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | in_byte, last_byte
//  out     | out_valid/out_stall| byte_valid, out_byte, frame_done,
//          |                    | frame_status
//  cfg     | APB psel/penable   | paddr, pwdata, prdata (0: exp. transaction,
//          |                    | 4: exp. unit)
//
// One word in, one word out; one byte per cycle sustained while out_stall is low.
// An accepted word is written to the queue, then moves into the output
// register when the back pops it.
// in_stall is the registered queue-full flag. In a steady stream the queue
// holds one word, so in_stall rises in the cycle after out_stall does; from an
// empty pipe three words (two queued, one in the output register) get in.
// Reset clears the byte counter, header capture, queue and output valid;
// the expected transaction and unit registers reset to zero.
// ----------------------------------------------------------------------------
module mbap_response_checker
	import mbap_rc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic        byte_valid,
	output logic [7:0]  out_byte,
	output logic        frame_done,
	output logic [2:0]  frame_status,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	logic     q_full, q_not_empty, q_pop, in_accept;
	qword_t   push_word, pop_word;

	// APB: registers are 32-bit aligned, index is paddr[2]
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_EXP_TRANSACTION: cfg_q.exp_transaction <= pwdata[15:0];
				REG_EXP_UNIT:        cfg_q.exp_unit        <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_EXP_TRANSACTION: prdata = {16'd0, cfg_q.exp_transaction};
			REG_EXP_UNIT:        prdata = {24'd0, cfg_q.exp_unit};
		endcase
	end

	// front: count and tag bytes; stall only on a full queue
	assign in_stall  = q_full;
	assign in_accept = in_valid && !q_full;

	mbap_rc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.push_word (push_word)
	);

	mbap_rc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept),
		.push_word (push_word),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop_word  (pop_word)
	);

	// back: header capture, checks and output register
	mbap_rc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_not_empty  (q_not_empty),
		.q_word       (pop_word),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.byte_valid   (byte_valid),
		.out_byte     (out_byte),
		.frame_done   (frame_done),
		.frame_status (frame_status)
	);

endmodule
